>>> hw/rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, status codes and register map for the point projection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int SIZE_W     = 14;

    // arithmetic widths, all exact
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int CLIP_W = SUM_W - FRAC_BITS;
    localparam int ADD_W  = CLIP_W + 1;
    localparam int NUM_W  = ADD_W + SIZE_W + 1;
    localparam int MAG_W  = NUM_W + FRAC_BITS;
    localparam int DEN_W  = CLIP_W;
    localparam int LIM_W  = DEN_W + DATA_WIDTH - 1;
    localparam int CMP_W  = (MAG_W > LIM_W ? MAG_W : LIM_W) + 1;

    // front stages before the divider, then one stage per quotient bit, then output
    localparam int PRE_STAGES = 6;
    localparam int NUM_STAGES = PRE_STAGES + DATA_WIDTH + 1;

    localparam int ADDR_W = 3;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1920);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1080);

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic [0:0] {
        REQ_PROJECT = 1'b0,
        REQ_COEF    = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BEHIND = 2'd1,
        ST_OVF    = 2'd2
    } status_t;

    typedef struct packed {
        logic    neg_x;
        logic    neg_y;
        status_t status;
    } side_t;

endpackage

`default_nettype wire

>>> hw/rtl/pps_div.sv
// ----------------------------------------------------------------------------
// pps_div
// Pipelined restoring divider: one quotient bit per stage, per-stage enables.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_div (
    input  wire logic                            aclk,
    input  wire logic [pps_pkg::DATA_WIDTH-1:0] en,
    input  wire logic [pps_pkg::DATA_WIDTH-1:0] num_lo,
    input  wire logic [pps_pkg::DEN_W-1:0]      rem_init,
    input  wire logic [pps_pkg::DEN_W-1:0]      den,
    output logic      [pps_pkg::DATA_WIDTH-1:0] quo,
    output logic                                rem_nz
);

    localparam int QW = pps_pkg::DATA_WIDTH;
    localparam int DW = pps_pkg::DEN_W;

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [QW-1:0] lo_reg  [QW];
    logic [DW-1:0] den_reg [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_step
            logic [DW-1:0] rp;
            logic [QW-1:0] qp;
            logic [QW-1:0] lp;
            logic [DW-1:0] dp;
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          ge;

            if (k == 0) begin : g_first
                assign rp = rem_init;
                assign qp = '0;
                assign lp = num_lo;
                assign dp = den;
            end else begin : g_next
                assign rp = rem_reg[k-1];
                assign qp = quo_reg[k-1];
                assign lp = lo_reg[k-1];
                assign dp = den_reg[k-1];
            end

            // shift in the next numerator bit, subtract when it fits
            assign trial = {rp, lp[QW-1]};
            assign ge    = trial >= {1'b0, dp};
            assign diff  = trial - {1'b0, dp};

            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    rem_reg[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                    quo_reg[k] <= {qp[QW-2:0], ge};
                    lo_reg[k]  <= {lp[QW-2:0], 1'b0};
                    den_reg[k] <= dp;
                end
            end
        end
    endgenerate

    assign quo    = quo_reg[QW-1];
    assign rem_nz = rem_reg[QW-1] != '0;

endmodule

`default_nettype wire

>>> hw/rtl/project_point_to_screen.sv
// ----------------------------------------------------------------------------
// project_point_to_screen
// Transforms a world point by a stored 4x4 matrix and maps it to pixels.
// ----------------------------------------------------------------------------
// Pipeline: 6 front stages, 32 divider stages and one output register from
//   accepted word to result. Throughput: one word per cycle unless stalled.
// Coefficient writes give no result.
// Reset: matrix cleared, viewport 1920x1080, pipeline emptied.
`default_nettype none

module project_point_to_screen (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_req_type,
    input  wire logic [3:0]                           s_coef_index,
    input  wire logic signed [pps_pkg::DATA_WIDTH-1:0] s_coef_value,
    input  wire logic signed [pps_pkg::DATA_WIDTH-1:0] s_world_x,
    input  wire logic signed [pps_pkg::DATA_WIDTH-1:0] s_world_y,
    input  wire logic signed [pps_pkg::DATA_WIDTH-1:0] s_world_z,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [pps_pkg::DATA_WIDTH-1:0]      m_screen_x,
    output logic signed [pps_pkg::DATA_WIDTH-1:0]      m_screen_y,
    output logic [1:0]                                m_status,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [pps_pkg::ADDR_W-1:0]           paddr,
    input  wire logic [31:0]                          pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    localparam int DW  = pps_pkg::DATA_WIDTH;
    localparam int FB  = pps_pkg::FRAC_BITS;
    localparam int NS  = pps_pkg::NUM_STAGES;
    localparam int PS  = pps_pkg::PRE_STAGES;
    localparam int PW  = pps_pkg::PROD_W;
    localparam int SW  = pps_pkg::SUM_W;
    localparam int CW  = pps_pkg::CLIP_W;
    localparam int AW  = pps_pkg::ADD_W;
    localparam int NW  = pps_pkg::NUM_W;
    localparam int MW  = pps_pkg::MAG_W;
    localparam int KW  = pps_pkg::CMP_W;
    localparam int ZW  = pps_pkg::SIZE_W;

    // ---------------- configuration ----------------
    logic [ZW-1:0] width_reg;
    logic [ZW-1:0] height_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= pps_pkg::WIDTH_RESET;
            height_reg <= pps_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == pps_pkg::REG_WIDTH) begin
                width_reg <= pwdata[ZW-1:0];
            end else begin
                height_reg <= pwdata[ZW-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == pps_pkg::REG_WIDTH) begin
            prdata = 32'(width_reg);
        end else begin
            prdata = 32'(height_reg);
        end
    end

    // ---------------- flow control ----------------
    logic [NS-1:0] vld_reg;
    logic [NS:0]   rdy;

    always_comb begin
        rdy[NS] = m_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_ready = rdy[0];

    logic s_acc;
    assign s_acc = s_valid && rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_valid && (s_req_type == pps_pkg::REQ_PROJECT);
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ---------------- matrix store ----------------
    logic [DW-1:0] mat_reg [16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                mat_reg[i] <= '0;
            end
        end else if (s_acc && s_req_type == pps_pkg::REQ_COEF) begin
            mat_reg[s_coef_index] <= s_coef_value;
        end
    end

    // ---------------- stage 0: capture point ----------------
    logic signed [DW-1:0] px_reg, py_reg, pz_reg;

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            px_reg <= s_world_x;
            py_reg <= s_world_y;
            pz_reg <= s_world_z;
        end
    end

    // ---------------- stage 1: nine products ----------------
    // row slot 0 is matrix row 0, slot 1 row 1, slot 2 row 3
    logic signed [PW-1:0] prod_reg [3][3];
    logic signed [DW-1:0] ofs_reg  [3];

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            for (int r = 0; r < 3; r++) begin
                prod_reg[r][0] <= $signed(mat_reg[(r == 2 ? 3 : r) * 4 + 0]) * px_reg;
                prod_reg[r][1] <= $signed(mat_reg[(r == 2 ? 3 : r) * 4 + 1]) * py_reg;
                prod_reg[r][2] <= $signed(mat_reg[(r == 2 ? 3 : r) * 4 + 2]) * pz_reg;
                ofs_reg[r]     <= $signed(mat_reg[(r == 2 ? 3 : r) * 4 + 3]);
            end
        end
    end

    // ---------------- stage 2: clip coordinates ----------------
    logic signed [SW-1:0] sum_c [3];
    logic signed [CW-1:0] clip_reg [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum_c[r] = {{2{prod_reg[r][0][PW-1]}}, prod_reg[r][0]}
                     + {{2{prod_reg[r][1][PW-1]}}, prod_reg[r][1]}
                     + {{2{prod_reg[r][2][PW-1]}}, prod_reg[r][2]}
                     + {{(SW-DW-FB){ofs_reg[r][DW-1]}}, ofs_reg[r], {FB{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            for (int r = 0; r < 3; r++) begin
                clip_reg[r] <= sum_c[r][SW-1:FB];
            end
        end
    end

    // ---------------- stage 3: numerator terms ----------------
    logic signed [AW-1:0] ax_reg, ay_reg;
    logic [CW-1:0]        den3_reg;
    logic                 behind3_reg;

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            ax_reg      <= {clip_reg[0][CW-1], clip_reg[0]} + {clip_reg[2][CW-1], clip_reg[2]};
            ay_reg      <= {clip_reg[2][CW-1], clip_reg[2]} - {clip_reg[1][CW-1], clip_reg[1]};
            den3_reg    <= {clip_reg[2][CW-2:0], 1'b0};
            behind3_reg <= clip_reg[2][CW-1] || (clip_reg[2] == '0);
        end
    end

    // ---------------- stage 4: viewport scaling ----------------
    logic signed [NW-1:0] nx_reg, ny_reg;
    logic [CW-1:0]        den4_reg;
    logic                 behind4_reg;

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            nx_reg      <= ax_reg * $signed({1'b0, width_reg});
            ny_reg      <= ay_reg * $signed({1'b0, height_reg});
            den4_reg    <= den3_reg;
            behind4_reg <= behind3_reg;
        end
    end

    // ---------------- stage 5: magnitude, range check ----------------
    logic [NW-1:0] magx, magy;
    logic [MW-1:0] mx, my, mx_sh, my_sh;
    logic [KW-1:0] lim, mxe, mye;
    logic          ovf_x, ovf_y;
    pps_pkg::side_t side5;

    logic [DW-1:0] lox_reg, loy_reg;
    logic [CW-1:0] r0x_reg, r0y_reg;
    logic [CW-1:0] den5_reg;
    pps_pkg::side_t side5_reg;

    always_comb begin
        magx  = nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
        magy  = ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
        mx    = {magx, {FB{1'b0}}};
        my    = {magy, {FB{1'b0}}};
        mx_sh = mx >> DW;
        my_sh = my >> DW;
        lim   = KW'(den4_reg) << (DW - 1);
        mxe   = KW'(mx);
        mye   = KW'(my);
        // floor of a negative quotient may reach exactly minus the limit
        ovf_x = nx_reg[NW-1] ? (mxe > lim) : (mxe >= lim);
        ovf_y = ny_reg[NW-1] ? (mye > lim) : (mye >= lim);
        side5.neg_x = nx_reg[NW-1];
        side5.neg_y = ny_reg[NW-1];
        if (behind4_reg) begin
            side5.status = pps_pkg::ST_BEHIND;
        end else if (ovf_x || ovf_y) begin
            side5.status = pps_pkg::ST_OVF;
        end else begin
            side5.status = pps_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            lox_reg   <= mx[DW-1:0];
            loy_reg   <= my[DW-1:0];
            r0x_reg   <= mx_sh[CW-1:0];
            r0y_reg   <= my_sh[CW-1:0];
            den5_reg  <= den4_reg;
            side5_reg <= side5;
        end
    end

    // ---------------- divider stages ----------------
    logic [DW-1:0]  div_en;
    logic [DW-1:0]  qx, qy;
    logic           nzx, nzy;
    pps_pkg::side_t side_reg [DW];

    assign div_en = rdy[PS+DW-1:PS];

    pps_div u_div_x (
        .aclk     (aclk),
        .en       (div_en),
        .num_lo   (lox_reg),
        .rem_init (r0x_reg),
        .den      (den5_reg),
        .quo      (qx),
        .rem_nz   (nzx)
    );

    pps_div u_div_y (
        .aclk     (aclk),
        .en       (div_en),
        .num_lo   (loy_reg),
        .rem_init (r0y_reg),
        .den      (den5_reg),
        .quo      (qy),
        .rem_nz   (nzy)
    );

    always_ff @(posedge aclk) begin
        if (div_en[0]) begin
            side_reg[0] <= side5_reg;
        end
        for (int k = 1; k < DW; k++) begin
            if (div_en[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------- output stage ----------------
    pps_pkg::side_t side_o;
    logic [DW:0]    fix_x, fix_y;
    logic [DW-1:0]  res_x, res_y;

    logic signed [DW-1:0] sx_reg, sy_reg;
    logic [1:0]           st_reg;

    always_comb begin
        side_o = side_reg[DW-1];
        fix_x  = {1'b0, qx} + (DW+1)'(nzx);
        fix_y  = {1'b0, qy} + (DW+1)'(nzy);
        res_x  = side_o.neg_x ? DW'(-fix_x) : qx;
        res_y  = side_o.neg_y ? DW'(-fix_y) : qy;
    end

    always_ff @(posedge aclk) begin
        if (rdy[NS-1]) begin
            st_reg <= side_o.status;
            if (side_o.status == pps_pkg::ST_OK) begin
                sx_reg <= res_x;
                sy_reg <= res_y;
            end else begin
                sx_reg <= '0;
                sy_reg <= '0;
            end
        end
    end

    assign m_valid    = vld_reg[NS-1];
    assign m_screen_x = sx_reg;
    assign m_screen_y = sy_reg;
    assign m_status   = st_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pps_chk.sv
// ----------------------------------------------------------------------------
// pps_chk
// Port-level checks for the point projection unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_chk (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [pps_pkg::DATA_WIDTH-1:0] m_screen_x,
    input wire logic [pps_pkg::DATA_WIDTH-1:0] m_screen_y,
    input wire logic [1:0]                     m_status,
    input wire logic                           pready
);

    // a stalled result word stays valid and keeps its x coordinate and status
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_screen_x) && $stable(m_status))
        else $error("result word dropped or changed under stall");

    // rejected points carry zero coordinates
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != pps_pkg::ST_OK |-> m_screen_x == '0 && m_screen_y == '0)
        else $error("nonzero coordinates with error status");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == pps_pkg::ST_OK || m_status == pps_pkg::ST_BEHIND
                 || m_status == pps_pkg::ST_OVF)
        else $error("undefined status code");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("register port stalled");

endmodule

bind project_point_to_screen pps_chk u_pps_chk (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_screen_x (m_screen_x),
    .m_screen_y (m_screen_y),
    .m_status   (m_status),
    .pready     (pready)
);

`default_nettype wire

>>> test/tb_project_point_to_screen.sv
// ----------------------------------------------------------------------------
// tb_project_point_to_screen
// Self-checking bench for the point projection unit. A directed table covers
// reset state, matrix loads, extreme points, w at or below zero and overflow.
// Random coefficient loads and points follow, under several viewport sizes.
// Both sides idle at random. Each result is checked against the expected
// value in the table or against a fixed-point model of the projection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_project_point_to_screen;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = pps_pkg::NUM_STAGES + 8;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;

    typedef struct {
        pps_pkg::req_t      kind;
        logic [3:0]         idx;
        logic signed [31:0] coef, x, y, z;
        logic               typed;
        pps_pkg::status_t   st;
        logic signed [31:0] ex, ey;
    } word_t;

    typedef struct {
        pps_pkg::status_t   st;
        logic signed [31:0] sx, sy;
    } pixel_t;

    logic aclk = 1'b0, aresetn = 1'b0;
    logic s_valid = 1'b0, s_req_type = 1'b0;
    logic [3:0] s_coef_index = '0;
    logic signed [31:0] s_coef_value = '0, s_world_x = '0, s_world_y = '0, s_world_z = '0;
    logic m_ready = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [pps_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire  m_valid, s_ready, pready;
    wire  signed [31:0] m_screen_x, m_screen_y;
    wire  [1:0] m_status;
    wire  [31:0] prdata;

    project_point_to_screen i_dut (.*);

    always #1 aclk = ~aclk;

    // model state
    logic signed [31:0] mat [16];
    logic [pps_pkg::SIZE_W-1:0] view_w, view_h;
    pixel_t pending_pixels [$];

    int fail_count = 0, cycles = 0;
    bit gaps_on = 0, stalls_on = 0, hold_req = 0;
    int hold_cnt = 0, stall_cnt = 0;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic signed [127:0] clip_row(int r, logic signed [127:0] x, y, z);
        logic signed [127:0] a0, a1, a2, a3, s;
        a0 = mat[r*4]; a1 = mat[r*4+1]; a2 = mat[r*4+2]; a3 = mat[r*4+3];
        s = a0 * x + a1 * y + a2 * z + (a3 <<< pps_pkg::FRAC_BITS);
        return s >>> pps_pkg::FRAC_BITS;
    endfunction

    function automatic logic signed [127:0] floor_div(logic signed [127:0] n, d);
        logic signed [127:0] q;
        q = n / d;
        if (n % d != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    function automatic pixel_t project_pixel(logic signed [31:0] wx, wy, wz);
        logic signed [127:0] x, y, z, cx, cy, cw, sx, sy, w, h;
        pixel_t p;
        x = wx; y = wy; z = wz;
        w = {114'd0, view_w};
        h = {114'd0, view_h};
        cx = clip_row(0, x, y, z);
        cy = clip_row(1, x, y, z);
        cw = clip_row(3, x, y, z);
        p = '{pps_pkg::ST_OK, '0, '0};
        if (cw <= 0) begin
            p.st = pps_pkg::ST_BEHIND;
            return p;
        end
        sx = floor_div(((cx + cw) * w) <<< pps_pkg::FRAC_BITS, cw * 2);
        sy = floor_div(((cw - cy) * h) <<< pps_pkg::FRAC_BITS, cw * 2);
        if (sx < -(128'sd1 <<< 31) || sx > (128'sd1 <<< 31) - 1 ||
            sy < -(128'sd1 <<< 31) || sy > (128'sd1 <<< 31) - 1) begin
            p.st = pps_pkg::ST_OVF;
            return p;
        end
        p.sx = sx[31:0];
        p.sy = sy[31:0];
        return p;
    endfunction

    task automatic check_pixel();
        pixel_t e;
        if (pending_pixels.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result x=%0d y=%0d st=%0d",
                         m_screen_x, m_screen_y, m_status);
            return;
        end
        e = pending_pixels.pop_front();
        if (m_status !== e.st || m_screen_x !== e.sx || m_screen_y !== e.sy) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch: exp x=%0d y=%0d st=%0d, got x=%0d y=%0d st=%0d",
                         e.sx, e.sy, e.st, m_screen_x, m_screen_y, m_status);
        end
    endtask

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                check_pixel();
                stall_cnt = stalls_on ? $urandom_range(0, 18) : 0;
            end
            if (hold_req) begin
                hold_cnt = 400;
                hold_req = 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(word_t wd);
        int gap;
        pixel_t p;
        gap = gaps_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= wd.kind;
        s_coef_index <= wd.idx;
        s_coef_value <= wd.coef;
        s_world_x    <= wd.x;
        s_world_y    <= wd.y;
        s_world_z    <= wd.z;
        do @(posedge aclk); while (!s_ready);
        if (wd.kind == pps_pkg::REQ_COEF) begin
            mat[wd.idx] = wd.coef;
        end else begin
            p = project_pixel(wd.x, wd.y, wd.z);
            if (wd.typed) p = '{wd.st, wd.ex, wd.ey};
            pending_pixels.push_back(p);
        end
    endtask

    // drop valid, then hold until every result is in and the pipeline has drained
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(pps_pkg::reg_index_t r, logic [31:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= pps_pkg::ADDR_W'(int'(r) * 4);
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (r == pps_pkg::REG_WIDTH) view_w = v[pps_pkg::SIZE_W-1:0];
        else view_h = v[pps_pkg::SIZE_W-1:0];
    endtask

    function automatic word_t mk(pps_pkg::req_t k, logic [3:0] i,
                                 logic signed [31:0] c, x, y, z,
                                 logic t = 0, pps_pkg::status_t st = pps_pkg::ST_OK,
                                 logic signed [31:0] ex = 0, ey = 0);
        word_t wd;
        wd = '{k, i, c, x, y, z, t, st, ex, ey};
        return wd;
    endfunction

    function automatic logic signed [31:0] rand_fix(int span);
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $signed($urandom_range(0, 2 * span * 65536)) - span * 65536;
    endfunction

    function automatic word_t rand_word();
        word_t wd;
        wd = mk(pps_pkg::REQ_PROJECT, 4'($urandom), $urandom,
                rand_fix(256), rand_fix(256), rand_fix(256));
        if ($urandom_range(0, 3) == 0) begin
            wd.kind = pps_pkg::REQ_COEF;
            case ($urandom_range(0, 2))
                0: wd.coef = rand_fix(4);
                1: wd.coef = $urandom;
                default: wd.coef = ONE + $signed($urandom_range(0, 4096)) - 2048;
            endcase
            // keep w mostly in front of the camera
            if (wd.idx == 15 && $urandom_range(0, 3) != 0)
                wd.coef = $urandom_range(1, 64 * 65536);
        end
        return wd;
    endfunction

    word_t directed [$];
    int phase_w [7] = '{1920, 1, 8192, 0, 16383, 640, 3};
    int phase_h [7] = '{1080, 1, 8192, 0, 5, 16383, 480};

    initial begin
        foreach (mat[i]) mat[i] = '0;
        view_w = pps_pkg::WIDTH_RESET;
        view_h = pps_pkg::HEIGHT_RESET;

        directed = '{
            mk(pps_pkg::REQ_PROJECT, 4'd0, SMIN, 0, 0, 0, 1, pps_pkg::ST_BEHIND),
            mk(pps_pkg::REQ_COEF, 4'd15, ONE, SMAX, SMIN, SMAX),
            mk(pps_pkg::REQ_COEF, 4'd0, ONE, 0, 0, 0),
            mk(pps_pkg::REQ_COEF, 4'd5, ONE, 0, 0, 0),
            mk(pps_pkg::REQ_PROJECT, 4'd15, SMAX, 0, 0, 0, 1, pps_pkg::ST_OK,
               960 <<< 16, 540 <<< 16),
            mk(pps_pkg::REQ_PROJECT, 4'd0, 0, ONE, 0, 0, 1, pps_pkg::ST_OK,
               1920 <<< 16, 540 <<< 16),
            mk(pps_pkg::REQ_PROJECT, 4'd0, 0, 0, -ONE, 0, 1, pps_pkg::ST_OK,
               960 <<< 16, 1080 <<< 16),
            mk(pps_pkg::REQ_PROJECT, 4'd0, 0, SMAX, 0, 0, 1, pps_pkg::ST_OVF),
            mk(pps_pkg::REQ_PROJECT, 4'd0, 0, SMIN, 0, 0, 1, pps_pkg::ST_OVF),
            mk(pps_pkg::REQ_PROJECT, 4'd0, 0, 0, 0, SMAX, 1, pps_pkg::ST_OK,
               960 <<< 16, 540 <<< 16),
            mk(pps_pkg::REQ_PROJECT, 4'd0, 0, 0, SMAX, SMIN, 1, pps_pkg::ST_OVF),
            mk(pps_pkg::REQ_COEF, 4'd15, -ONE, 0, 0, 0),
            mk(pps_pkg::REQ_PROJECT, 4'd0, 0, 0, 0, 0, 1, pps_pkg::ST_BEHIND),
            mk(pps_pkg::REQ_COEF, 4'd15, 0, 0, 0, 0),
            mk(pps_pkg::REQ_PROJECT, 4'd0, 0, 0, 0, 0, 1, pps_pkg::ST_BEHIND),
            mk(pps_pkg::REQ_COEF, 4'd15, 32'sd1, 0, 0, 0),
            mk(pps_pkg::REQ_PROJECT, 4'd0, 0, 0, 0, 0, 1, pps_pkg::ST_OK,
               960 <<< 16, 540 <<< 16),
            mk(pps_pkg::REQ_COEF, 4'd14, SMAX, 0, 0, 0),
            mk(pps_pkg::REQ_COEF, 4'd12, SMIN, 0, 0, 0),
            mk(pps_pkg::REQ_COEF, 4'd1, SMAX, 0, 0, 0),
            mk(pps_pkg::REQ_PROJECT, 4'd0, 0, SMAX, SMIN, SMAX),
            mk(pps_pkg::REQ_COEF, 4'd3, 3 * ONE, 0, 0, 0),
            mk(pps_pkg::REQ_COEF, 4'd15, 8 * ONE, 0, 0, 0),
            mk(pps_pkg::REQ_PROJECT, 4'd0, 0, -ONE, ONE, -ONE),
            mk(pps_pkg::REQ_PROJECT, 4'd0, 0, 32'sh0000_FFFF, 32'sh0001_8000, 32'sh0000_0001)
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_word(directed[i]);

        for (int ph = 0; ph < 7; ph++) begin
            wait_idle();
            write_reg(pps_pkg::REG_WIDTH, phase_w[ph]);
            write_reg(pps_pkg::REG_HEIGHT, phase_h[ph]);
            gaps_on   = (ph == 0 || ph == 3) ? 0 : $urandom_range(0, 1) | (ph > 4);
            stalls_on = (ph == 0) ? 0 : $urandom_range(0, 1) | (ph > 4);
            // fill the pipeline against a blocked output
            if (ph == 3) hold_req = 1;
            for (int n = 0; n < 65; n++) send_word(rand_word());
        end
        s_valid <= 1'b0;

        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/pps_pkg.sv
hw/rtl/pps_div.sv
hw/rtl/project_point_to_screen.sv
hw/rtl/pps_chk.sv
test/tb_project_point_to_screen.sv
